@@ sv/ctn_pkg.sv @@
// Shared types, constants and helpers for the chord template namer.
// No dependencies; ctn_accum, ctn_match and the top level import this package.
`default_nettype none

package ctn_pkg;

  localparam int NUM_PCS    = 12;
  localparam int NUM_SHAPES = 13;

  // Lowest-note register value when no valid note has been heard.
  localparam logic [6:0] LOW_NOTE_RESET = 7'd127;

  // Interval shapes in priority order, bit k = interval of k semitones.
  localparam logic [NUM_PCS-1:0] SHAPES [NUM_SHAPES] = '{
    12'h491,  // dominant seventh
    12'h891,  // major seventh
    12'h489,  // minor seventh
    12'h449,  // half diminished
    12'h249,  // diminished seventh
    12'h889,  // minor major seventh
    12'h091,  // major
    12'h089,  // minor
    12'h049,  // diminished
    12'h111,  // augmented
    12'h0A1,  // sus4
    12'h085,  // sus2
    12'h081   // power chord
  };

  typedef enum logic [2:0] {
    ST_EMPTY   = 3'd0,
    ST_SINGLE  = 3'd1,
    ST_ROOT    = 3'd2,
    ST_INV     = 3'd3,
    ST_NOMATCH = 3'd4
  } status_e;

  // Snapshot of the accumulated chord, valid on the final note.
  typedef struct packed {
    logic [NUM_PCS-1:0] pitch_set;
    logic [6:0]         lowest;
    logic               single;
  } chord_t;

  typedef struct packed {
    status_e            status;
    logic [3:0]         root;
    logic [3:0]         quality;
    logic [3:0]         bass;
    logic [NUM_PCS-1:0] pitch_set;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] idx;
  } shape_hit_t;

  // n mod 12 for n < 128: quotient by reciprocal 43/512, exact in this range.
  function automatic logic [3:0] mod12(input logic [6:0] n);
    logic [12:0] prod;
    logic [3:0]  quo;
    logic [6:0]  rem;
    prod = 13'(n) * 13'd43;
    quo  = prod[12:9];
    rem  = n - ({quo, 3'b000} + {1'b0, quo, 2'b00});
    return rem[3:0];
  endfunction

  // First shape equal to a rotated set; lowest index wins.
  function automatic shape_hit_t shape_match(input logic [NUM_PCS-1:0] rot);
    shape_hit_t res;
    res = '0;
    for (int i = NUM_SHAPES - 1; i >= 0; i--) begin
      if (rot == SHAPES[i]) begin
        res.hit = 1'b1;
        res.idx = 4'(i);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ sv/ctn_note_if.sv @@
// Valid/ready channel interfaces for note input and chord results.
// Stand-alone; payload widths follow the block's field list.
`default_nettype none

interface ctn_note_if;
  logic       valid;
  logic       ready;
  logic [7:0] note;
  logic       last;

  modport source (output valid, output note, output last, input ready);
  modport sink   (input valid, input note, input last, output ready);
endinterface

interface ctn_chord_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  root;
  logic [3:0]  quality;
  logic [3:0]  bass;
  logic [11:0] pitch_set;

  modport source (output valid, output status, output root, output quality,
                  output bass, output pitch_set, input ready);
  modport sink   (input valid, input status, input root, input quality,
                  input bass, input pitch_set, output ready);
endinterface

`default_nettype wire

@@ sv/ctn_accum.sv @@
// Chord accumulator: pitch-class set, lowest valid note, saturating count.
// Depends on ctn_pkg.
`default_nettype none

module ctn_accum (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic [7:0]    note_i,
  input  wire logic          last_i,
  output ctn_pkg::chord_t    chord_o
);
  import ctn_pkg::*;

  logic [NUM_PCS-1:0] set_q, set_d;
  logic [6:0]         low_q, low_d;
  logic [1:0]         cnt_q, cnt_d;
  logic               note_ok;
  logic [NUM_PCS-1:0] set_nxt;
  logic [6:0]         low_nxt;

  assign note_ok = ~note_i[7];

  always_comb begin
    set_nxt = set_q;
    low_nxt = low_q;
    if (note_ok) begin
      set_nxt = set_q | (NUM_PCS'(1) << mod12(note_i[6:0]));
      if (note_i[6:0] < low_q) begin
        low_nxt = note_i[6:0];
      end
    end
    set_d = set_q;
    low_d = low_q;
    cnt_d = cnt_q;
    if (en_i) begin
      if (last_i) begin
        set_d = '0;
        low_d = LOW_NOTE_RESET;
        cnt_d = '0;
      end else begin
        set_d = set_nxt;
        low_d = low_nxt;
        cnt_d = (cnt_q == 2'd2) ? cnt_q : cnt_q + 2'd1;
      end
    end
  end

  // Count after this note is one exactly when nothing was counted before.
  assign chord_o.pitch_set = set_nxt;
  assign chord_o.lowest    = low_nxt;
  assign chord_o.single    = (cnt_q == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_q <= '0;
      low_q <= LOW_NOTE_RESET;
      cnt_q <= '0;
    end else begin
      set_q <= set_d;
      low_q <= low_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/ctn_match.sv @@
// Chord classifier: twelve rotations of the set against the shape table.
// Depends on ctn_pkg.
`default_nettype none

module ctn_match (
  input  wire ctn_pkg::chord_t chord_i,
  output ctn_pkg::result_t     result_o
);
  import ctn_pkg::*;

  logic [2*NUM_PCS-1:0] dbl;
  shape_hit_t           hits [NUM_PCS];
  logic [3:0]           bass;
  logic                 inv_found;
  logic [3:0]           inv_root;
  logic [3:0]           inv_qual;

  assign dbl  = {chord_i.pitch_set, chord_i.pitch_set};
  assign bass = mod12(chord_i.lowest);

  always_comb begin
    for (int r = 0; r < NUM_PCS; r++) begin
      hits[r] = shape_match(dbl[r +: NUM_PCS]);
    end
  end

  // First root from C upward, other than the bass, that fits a shape.
  always_comb begin
    inv_found = 1'b0;
    inv_root  = '0;
    inv_qual  = '0;
    for (int r = 0; r < NUM_PCS; r++) begin
      if (!inv_found && (4'(r) != bass) && hits[r].hit) begin
        inv_found = 1'b1;
        inv_root  = 4'(r);
        inv_qual  = hits[r].idx;
      end
    end
  end

  always_comb begin
    result_o           = '0;
    result_o.status    = ST_EMPTY;
    result_o.pitch_set = chord_i.pitch_set;
    if (chord_i.pitch_set != '0) begin
      result_o.bass = bass;
      if (chord_i.single) begin
        result_o.status = ST_SINGLE;
        result_o.root   = bass;
      end else if (hits[bass].hit) begin
        result_o.status  = ST_ROOT;
        result_o.root    = bass;
        result_o.quality = hits[bass].idx;
      end else if (inv_found) begin
        result_o.status  = ST_INV;
        result_o.root    = inv_root;
        result_o.quality = inv_qual;
      end else begin
        result_o.status = ST_NOMATCH;
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/chord_template_namer_core.sv @@
// Chord template namer, top level: input register, accumulator, classifier,
// result register. Depends on ctn_pkg, ctn_note_if.sv, ctn_accum, ctn_match.
//
// Usage:
//   note_i carries one MIDI note per transaction plus a last flag. Notes above
//   127 add nothing to the pitch-class set or the bass, but they count as
//   notes. The transaction with last set closes the chord and produces one
//   transaction on chord_o (status, root, quality, bass, pitch_set); other
//   notes produce none. After a chord closes the accumulator is clear again.
// Path: a closing note passes two register stages (input register, then
//   result register) before it shows on chord_o.
// Throughput: one note per cycle but for the stall below. The set update,
//   twelve rotations and the shape compares all sit between the input and result registers.
// Stall: while a result waits on chord_o, notes that do not close a chord
//   still flow into the accumulator; a closing note waits in the input
//   register until the result register is free, and note_i.ready drops then.
// Reset: rst_ni (async, active low) empties both register stages and clears
//   the accumulator (empty set, lowest note 127, count zero).
`default_nettype none

module chord_template_namer_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  ctn_note_if.sink    note_i,
  ctn_chord_if.source chord_o
);
  import ctn_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] note_q;
  logic       last_q;
  logic       out_vld_q, out_vld_d;
  result_t    res_q;
  logic       stage_go;
  logic       in_take;
  chord_t     chord;
  result_t    res;

  // A closing note needs a free result register; other notes never wait.
  assign stage_go = in_vld_q & (~last_q | ~out_vld_q | chord_o.ready);
  assign note_i.ready = ~in_vld_q | stage_go;
  assign in_take = note_i.valid & note_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_take) begin
      in_vld_d = 1'b1;
    end else if (stage_go) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (stage_go && last_q) begin
      out_vld_d = 1'b1;
    end else if (chord_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      note_q <= note_i.note;
      last_q <= note_i.last;
    end
    if (stage_go && last_q) begin
      res_q <= res;
    end
  end

  ctn_accum u_accum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (stage_go),
    .note_i  (note_q),
    .last_i  (last_q),
    .chord_o (chord)
  );

  ctn_match u_match (
    .chord_i  (chord),
    .result_o (res)
  );

  assign chord_o.valid     = out_vld_q;
  assign chord_o.status    = res_q.status;
  assign chord_o.root      = res_q.root;
  assign chord_o.quality   = res_q.quality;
  assign chord_o.bass      = res_q.bass;
  assign chord_o.pitch_set = res_q.pitch_set;

`ifndef NO_ASSERTIONS
  // Root position names the bass as root; an inversion never does.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && (res_q.status == ST_ROOT || res_q.status == ST_INV) |->
      ((res_q.root == res_q.bass) == (res_q.status == ST_ROOT)))
    else $error("root/bass relation wrong for matched chord");

  // A single-note result carries exactly one pitch class, equal to the bass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.status == ST_SINGLE |->
      $onehot(res_q.pitch_set) && res_q.pitch_set[res_q.bass])
    else $error("single-note result inconsistent");

  // An empty chord reports nothing at all.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && res_q.status == ST_EMPTY |->
      res_q.pitch_set == '0 && res_q.bass == '0 && res_q.root == '0)
    else $error("empty result carries data");

  // A waiting closing note holds the input stage without touching the result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && last_q && !stage_go |=> in_vld_q && $stable(res_q))
    else $error("closing note lost or result overwritten during stall");
`endif

endmodule

`default_nettype wire
